// ----- rtl/duration_string_parser_unit_assert.svh -----
// ----------------------------------------------------------------------------
// duration string parser assertion macros
// concurrent assertion shorthands sampled on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef DURATION_STRING_PARSER_UNIT_ASSERT_SVH
`define DURATION_STRING_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define DSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dsp_pkg
// widths, character codes, unit factors and power-of-ten table for the
// duration string parser
// ----------------------------------------------------------------------------
package dsp_pkg;

    // fraction digit limit
    localparam int MAX_FRACTION_DIGITS = 6;

    // field and state widths
    localparam int CODE_W   = 16;
    localparam int MANT_W   = 40;
    localparam int FD_W     = 3;
    localparam int TOTAL_W  = 63;
    localparam int FACTOR_W = 32;
    localparam int HALF_W   = MANT_W / 2;
    localparam int HPROD_W  = HALF_W + FACTOR_W;
    localparam int PROD_W   = MANT_W + FACTOR_W;
    localparam int DIV_W    = 24;
    localparam int DIV_BITS = PROD_W;
    localparam int CNT_W    = $clog2(DIV_BITS);

    // saturation limits
    localparam logic [MANT_W-1:0]  MANT_MAX  = {MANT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // character codes
    localparam logic [CODE_W-1:0] CHAR_0      = 16'h0030;
    localparam logic [CODE_W-1:0] CHAR_9      = 16'h0039;
    localparam logic [CODE_W-1:0] CHAR_DOT    = 16'h002E;
    localparam logic [CODE_W-1:0] CHAR_LOWER_H = 16'h0068;
    localparam logic [CODE_W-1:0] CHAR_LOWER_M = 16'h006D;
    localparam logic [CODE_W-1:0] CHAR_LOWER_S = 16'h0073;

    // time units
    typedef enum logic [1:0] {
        UNIT_HOUR,
        UNIT_MINUTE,
        UNIT_SECOND,
        UNIT_MILLI
    } unit_t;

    // microseconds per unit
    function automatic logic [FACTOR_W-1:0] unit_factor(unit_t unit);
        logic [FACTOR_W-1:0] f;
        case (unit)
            UNIT_HOUR:   f = 32'd3600000000;
            UNIT_MINUTE: f = 32'd60000000;
            UNIT_SECOND: f = 32'd1000000;
            UNIT_MILLI:  f = 32'd1000;
            default:     f = 32'd1000;
        endcase
        return f;
    endfunction

    // divisor for a count of fraction digits
    function automatic logic [DIV_W-1:0] pow10(logic [FD_W-1:0] n);
        logic [DIV_W-1:0] p;
        case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/duration_string_parser_unit.sv -----
// ----------------------------------------------------------------------------
// duration_string_parser_unit
// parses h / m / s / ms duration text one character per item and returns the
// total in microseconds on the end item
// ----------------------------------------------------------------------------
// Each input item is one character; an item with end_of_text set closes the
// text and yields one result (total_us, valid_res, overflowed), after which
// all state is cleared. Input stall is high whenever the sequencer is busy.
// A digit, dot or unknown character is accepted in idle and handled in
// decode. A unit character (h, s, or the character that resolves a pending
// m) adds a scaling pass on a shared 20x32 multiplier: a low and a high
// multiply, one sum, 72 restoring division steps when the number has
// fraction digits (none otherwise) and one accumulate; the character after
// a pending m that is not s then goes back to decode. The end item passes
// through decode and finish, plus one scaling pass when a minute is still
// pending. The result sits in an output register, so characters of the next
// text are taken while it waits.
// ----------------------------------------------------------------------------
`include "duration_string_parser_unit_assert.svh"

module duration_string_parser_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dsp_pkg::CODE_W-1:0]    code,
    input  logic                          end_of_text,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dsp_pkg::TOTAL_W-1:0]   total_us,
    output logic                          valid_res,
    output logic                          overflowed
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIV,
        ST_ACC,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [dsp_pkg::CODE_W-1:0]      code_reg, code_next;
    logic                            eot_reg, eot_next;
    logic [dsp_pkg::MANT_W-1:0]      mant_reg, mant_next;
    logic [dsp_pkg::FD_W-1:0]        fd_reg, fd_next;
    logic                            in_frac_reg, in_frac_next;
    logic                            pending_reg, pending_next;
    logic                            seen_reg, seen_next;
    logic [dsp_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic                            sat_reg, sat_next;
    logic                            replay_reg, replay_next;
    dsp_pkg::unit_t                  unit_reg, unit_next;
    logic [dsp_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [dsp_pkg::HPROD_W-1:0]     part_reg, part_next;
    logic [dsp_pkg::DIV_W-1:0]       rem_reg, rem_next;
    logic [dsp_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [dsp_pkg::TOTAL_W-1:0]     out_total_reg, out_total_next;
    logic                            out_vres_reg, out_vres_next;
    logic                            out_ovf_reg, out_ovf_next;

    logic                            is_digit;
    logic [3:0]                      digit;
    logic [dsp_pkg::MANT_W+3:0]      mant_x10;
    logic [dsp_pkg::HALF_W-1:0]      mul_a;
    logic [dsp_pkg::HPROD_W-1:0]     mul_out;
    logic [dsp_pkg::DIV_W-1:0]       divisor;
    logic [dsp_pkg::DIV_W:0]         div_trial;
    logic [dsp_pkg::DIV_W:0]         div_diff;
    logic                            div_fits;
    logic                            part_sat;
    logic [dsp_pkg::TOTAL_W-1:0]     part;
    logic [dsp_pkg::TOTAL_W:0]       acc_sum;

    // handshake
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign total_us   = out_total_reg;
    assign valid_res  = out_vres_reg;
    assign overflowed = out_ovf_reg;

    // digit decode and mantissa times ten plus digit
    assign is_digit = (code_reg >= dsp_pkg::CHAR_0) && (code_reg <= dsp_pkg::CHAR_9);
    assign digit    = code_reg[3:0];
    assign mant_x10 = ({4'b0, mant_reg} << 3) + ({4'b0, mant_reg} << 1)
                    + {{dsp_pkg::MANT_W{1'b0}}, digit};

    // shared half-width multiplier
    assign mul_a   = (state_reg == ST_MUL_HI) ? mant_reg[dsp_pkg::MANT_W-1:dsp_pkg::HALF_W]
                                              : mant_reg[dsp_pkg::HALF_W-1:0];
    assign mul_out = {{dsp_pkg::FACTOR_W{1'b0}}, mul_a}
                   * {{dsp_pkg::HALF_W{1'b0}}, dsp_pkg::unit_factor(unit_reg)};

    // restoring division step
    assign divisor   = dsp_pkg::pow10(fd_reg);
    assign div_trial = {rem_reg, prod_reg[dsp_pkg::PROD_W-1]};
    assign div_fits  = (div_trial >= {1'b0, divisor});
    assign div_diff  = div_trial - {1'b0, divisor};

    // clamp scaled part and add to running total
    assign part_sat = |prod_reg[dsp_pkg::PROD_W-1:dsp_pkg::TOTAL_W];
    assign part     = part_sat ? dsp_pkg::TOTAL_MAX : prod_reg[dsp_pkg::TOTAL_W-1:0];
    assign acc_sum  = {1'b0, total_reg} + {1'b0, part};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        eot_next       = eot_reg;
        mant_next      = mant_reg;
        fd_next        = fd_reg;
        in_frac_next   = in_frac_reg;
        pending_next   = pending_reg;
        seen_next      = seen_reg;
        total_next     = total_reg;
        sat_next       = sat_reg;
        replay_next    = replay_reg;
        unit_next      = unit_reg;
        prod_next      = prod_reg;
        part_next      = part_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_total_next = out_total_reg;
        out_vres_next  = out_vres_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    code_next  = code;
                    eot_next   = end_of_text;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                if (pending_reg)
                begin
                    // resolve the pending m first
                    pending_next = 1'b0;
                    state_next   = ST_MUL_LO;
                    if (!eot_reg && (code_reg == dsp_pkg::CHAR_LOWER_S))
                    begin
                        unit_next   = dsp_pkg::UNIT_MILLI;
                        replay_next = 1'b0;
                    end
                    else
                    begin
                        unit_next   = dsp_pkg::UNIT_MINUTE;
                        replay_next = 1'b1;
                    end
                end
                else if (eot_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (is_digit)
                begin
                    seen_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (!in_frac_reg
                        || (fd_reg < dsp_pkg::FD_W'(dsp_pkg::MAX_FRACTION_DIGITS)))
                    begin
                        if (in_frac_reg)
                        begin
                            fd_next = fd_reg + 1'b1;
                        end
                        if (|mant_x10[dsp_pkg::MANT_W+3:dsp_pkg::MANT_W])
                        begin
                            mant_next = dsp_pkg::MANT_MAX;
                            sat_next  = 1'b1;
                        end
                        else
                        begin
                            mant_next = mant_x10[dsp_pkg::MANT_W-1:0];
                        end
                    end
                end
                else if (code_reg == dsp_pkg::CHAR_DOT)
                begin
                    in_frac_next = 1'b1;
                    seen_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (code_reg == dsp_pkg::CHAR_LOWER_M)
                begin
                    pending_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (code_reg == dsp_pkg::CHAR_LOWER_H)
                begin
                    unit_next   = dsp_pkg::UNIT_HOUR;
                    replay_next = 1'b0;
                    state_next  = ST_MUL_LO;
                end
                else if (code_reg == dsp_pkg::CHAR_LOWER_S)
                begin
                    unit_next   = dsp_pkg::UNIT_SECOND;
                    replay_next = 1'b0;
                    state_next  = ST_MUL_LO;
                end
                else
                begin
                    // unknown character drops the number
                    mant_next    = '0;
                    fd_next      = '0;
                    in_frac_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            ST_MUL_LO:
            begin
                prod_next  = dsp_pkg::PROD_W'(mul_out);
                state_next = ST_MUL_HI;
            end

            ST_MUL_HI:
            begin
                part_next  = mul_out;
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                prod_next = prod_reg + {part_reg, {dsp_pkg::HALF_W{1'b0}}};
                rem_next  = '0;
                cnt_next  = '0;
                if (fd_reg == '0)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next  = div_fits ? div_diff[dsp_pkg::DIV_W-1:0]
                                     : div_trial[dsp_pkg::DIV_W-1:0];
                prod_next = {prod_reg[dsp_pkg::PROD_W-2:0], div_fits};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == dsp_pkg::CNT_W'(dsp_pkg::DIV_BITS - 1))
                begin
                    state_next = ST_ACC;
                end
            end

            ST_ACC:
            begin
                if (acc_sum[dsp_pkg::TOTAL_W])
                begin
                    total_next = dsp_pkg::TOTAL_MAX;
                end
                else
                begin
                    total_next = acc_sum[dsp_pkg::TOTAL_W-1:0];
                end
                sat_next     = sat_reg || part_sat || acc_sum[dsp_pkg::TOTAL_W];
                mant_next    = '0;
                fd_next      = '0;
                in_frac_next = 1'b0;
                replay_next  = 1'b0;
                state_next   = replay_reg ? ST_DECODE : ST_IDLE;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = seen_reg ? total_reg : '0;
                    out_vres_next  = seen_reg;
                    out_ovf_next   = sat_reg;
                    mant_next      = '0;
                    fd_next        = '0;
                    in_frac_next   = 1'b0;
                    pending_next   = 1'b0;
                    seen_next      = 1'b0;
                    total_next     = '0;
                    sat_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            code_reg      <= '0;
            eot_reg       <= 1'b0;
            mant_reg      <= '0;
            fd_reg        <= '0;
            in_frac_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            replay_reg    <= 1'b0;
            unit_reg      <= dsp_pkg::UNIT_HOUR;
            prod_reg      <= '0;
            part_reg      <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
            out_vres_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            eot_reg       <= eot_next;
            mant_reg      <= mant_next;
            fd_reg        <= fd_next;
            in_frac_reg   <= in_frac_next;
            pending_reg   <= pending_next;
            seen_reg      <= seen_next;
            total_reg     <= total_next;
            sat_reg       <= sat_next;
            replay_reg    <= replay_next;
            unit_reg      <= unit_next;
            prod_reg      <= prod_next;
            part_reg      <= part_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_total_reg <= out_total_next;
            out_vres_reg  <= out_vres_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    // assertions
    `DSP_ASSERT_IMP(a_fd_limit, 1'b1, fd_reg <= dsp_pkg::FD_W'(dsp_pkg::MAX_FRACTION_DIGITS), "fraction digit count beyond limit")
    `DSP_ASSERT_IMP(a_div_rem, state_reg == ST_DIV, rem_reg < divisor, "division remainder not below divisor")
    `DSP_ASSERT_IMP(a_finish_no_pending, state_reg == ST_FINISH, !pending_reg, "pending minute left at finish")
    `DSP_ASSERT_NXT(a_end_decoded, in_valid && !in_stall && end_of_text, state_reg == ST_DECODE && eot_reg, "end item not taken to decode")
    `DSP_ASSERT_IMP(a_result_source, $rose(out_valid_reg), $past(state_reg == ST_FINISH), "result raised outside finish")

endmodule
